>>> rtl/blfa_pkg.sv
package blfa_pkg;

  // Pool geometry.
  localparam int NUM_WORDS = 64;
  localparam int WORD_BITS = 64;
  localparam int ID_W      = 12;

  localparam int ID_CAP   = 1 << ID_W;
  localparam int RAW_IDS  = NUM_WORDS * WORD_BITS;
  localparam int POOL_IDS = (RAW_IDS < ID_CAP) ? RAW_IDS : ID_CAP;

  localparam int WADDR_W = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1;
  localparam int BIT_W   = $clog2(WORD_BITS);
  // Wide enough for any linear index and for POOL_IDS itself.
  localparam int LIN_W   = $clog2(RAW_IDS) + 1;

  // Identifier to word index by multiplication with a rounded-up reciprocal.
  // The shift leaves enough headroom that the quotient is exact over ID_W bits.
  localparam int DIV_SH    = ID_W + 7;
  localparam int DIV_RECIP = ((1 << DIV_SH) + WORD_BITS - 1) / WORD_BITS;
  localparam int RECIP_W   = DIV_SH + 1;
  localparam int PROD_W    = ID_W + RECIP_W;

  localparam logic REQ_ALLOC = 1'b0;
  localparam logic REQ_FREE  = 1'b1;

  typedef enum logic [1:0] {
    STAT_OK        = 2'd0,
    STAT_EMPTY     = 2'd1,
    STAT_NOT_ALLOC = 2'd2
  } status_t;

  typedef enum logic {
    ST_IDLE,
    ST_MOD
  } state_t;

  typedef struct packed {
    logic                 en;
    logic [WADDR_W-1:0]   addr;
    logic [WORD_BITS-1:0] data;
  } wr_req_t;

  // Position of the lowest clear bit; 0 when the word is full.
  function automatic logic [BIT_W-1:0] first_zero(input logic [WORD_BITS-1:0] w);
    logic [BIT_W-1:0] pos;
    pos = '0;
    for (int i = WORD_BITS - 1; i >= 0; i--) begin
      if (!w[i]) begin
        pos = BIT_W'(i);
      end
    end
    return pos;
  endfunction

endpackage

>>> rtl/blfa_store.sv
module blfa_store
  import blfa_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 rd_en,
  input  logic [WADDR_W-1:0]   rd_addr,
  output logic [WORD_BITS-1:0] rd_data,
  input  wr_req_t              wr,
  output logic [NUM_WORDS-1:0] full
);

  // Bitmap words. A word never written since reset reads as all free.
  logic [WORD_BITS-1:0] mem [NUM_WORDS];
  logic [WORD_BITS-1:0] rdata_r;
  logic                 rvalid_r;
  logic [NUM_WORDS-1:0] valid_r;
  logic [NUM_WORDS-1:0] full_r;

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
    if (rd_en) begin
      rdata_r <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r  <= '0;
      full_r   <= '0;
      rvalid_r <= 1'b0;
    end else begin
      if (rd_en) begin
        rvalid_r <= valid_r[rd_addr];
      end
      if (wr.en) begin
        valid_r[wr.addr] <= 1'b1;
        full_r[wr.addr]  <= &wr.data;
      end
    end
  end

  assign rd_data = rvalid_r ? rdata_r : '0;
  assign full    = full_r;

endmodule

>>> rtl/bitmap_lowest_free_id_allocator.sv
// Channel   Ports                                   Handshake
// -------   -------------------------------------   -------------------------------
// input     in_req_type, in_id_to_free              start high and busy low at edge
// result    out_status, out_granted_id              out_valid high for one cycle
//
// For every request, the word is read from the bitmap memory in the accept
// cycle and modified and written back in the next one, during which busy is
// high. The result word appears in the cycle after that, and a new request
// may be accepted in that same cycle. Reset clears the per-word valid and
// full flags at once, so the block is ready as soon as reset is released.
// The receiver cannot stall; every result is shown for exactly one cycle.
module bitmap_lowest_free_id_allocator
  import blfa_pkg::*;
(
  input  logic            clk,
  input  logic            rst_n,
  input  logic            start,
  output logic            busy,
  input  logic            in_req_type,
  input  logic [ID_W-1:0] in_id_to_free,
  output logic            out_valid,
  output logic [1:0]      out_status,
  output logic [ID_W-1:0] out_granted_id
);

  state_t state_r, state_nxt;

  logic                 accept;
  logic [NUM_WORDS-1:0] full;
  logic [WORD_BITS-1:0] rd_data;
  logic [WADDR_W-1:0]   rd_addr;
  wr_req_t              wr;

  // Request registers, loaded when a word is accepted.
  logic                 req_type_r;
  logic [ID_W-1:0]      id_r;
  logic [WADDR_W-1:0]   waddr_r;
  logic                 oob_r;
  logic                 empty_r;

  // Result registers.
  logic                 out_valid_r;
  status_t              out_status_r, status_nxt;
  logic [ID_W-1:0]      out_granted_id_r, granted_nxt;

  // The lowest word that still has a clear bit. Full words are tracked by one
  // flag each, so the search never touches the memory.
  logic [WADDR_W-1:0]   free_word;
  logic                 any_free;

  always_comb begin
    free_word = '0;
    any_free  = 1'b0;
    for (int i = NUM_WORDS - 1; i >= 0; i--) begin
      if (!full[i]) begin
        free_word = WADDR_W'(i);
        any_free  = 1'b1;
      end
    end
  end

  // Word index of the identifier to free, by reciprocal multiplication.
  logic [PROD_W-1:0] div_prod;
  logic [WADDR_W-1:0] free_addr;
  logic               free_oob;

  assign div_prod  = PROD_W'(in_id_to_free) * PROD_W'(DIV_RECIP);
  assign free_addr = div_prod[DIV_SH +: WADDR_W];
  assign free_oob  = LIN_W'(in_id_to_free) >= LIN_W'(POOL_IDS);

  assign accept  = start && !busy;
  assign rd_addr = (in_req_type == REQ_FREE) ? free_addr : free_word;

  blfa_store u_store (
    .clk     (clk),
    .rst_n   (rst_n),
    .rd_en   (accept),
    .rd_addr (rd_addr),
    .rd_data (rd_data),
    .wr      (wr),
    .full    (full)
  );

  always_ff @(posedge clk) begin
    if (accept) begin
      req_type_r <= in_req_type;
      id_r       <= in_id_to_free;
      waddr_r    <= rd_addr;
      oob_r      <= free_oob;
      empty_r    <= !any_free;
    end
  end

  // Next state: the modify step follows every accepted request.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (start) begin
          state_nxt = ST_MOD;
        end
      end
      ST_MOD: begin
        state_nxt = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Modify step. The write lands at the end of this cycle and the next read is
  // issued no earlier than the following cycle, so no forwarding is needed.
  logic [BIT_W-1:0]     alloc_bit;
  logic [LIN_W-1:0]     word_base;
  logic [LIN_W-1:0]     alloc_id;
  logic [LIN_W-1:0]     free_off;
  logic [BIT_W-1:0]     free_bit;

  assign alloc_bit = first_zero(rd_data);
  assign word_base = LIN_W'(waddr_r) * LIN_W'(WORD_BITS);
  assign alloc_id  = word_base + LIN_W'(alloc_bit);
  assign free_off  = LIN_W'(id_r) - word_base;
  assign free_bit  = free_off[BIT_W-1:0];

  always_comb begin
    busy        = 1'b0;
    wr.en       = 1'b0;
    wr.addr     = waddr_r;
    wr.data     = rd_data;
    status_nxt  = STAT_OK;
    granted_nxt = '0;
    unique case (state_r)
      ST_IDLE: begin
        busy = 1'b0;
      end
      ST_MOD: begin
        busy = 1'b1;
        if (req_type_r == REQ_ALLOC) begin
          // A free bit beyond the identifier range means the pool is used up.
          if (empty_r || (alloc_id >= LIN_W'(POOL_IDS))) begin
            status_nxt = STAT_EMPTY;
          end else begin
            wr.en              = 1'b1;
            wr.data[alloc_bit] = 1'b1;
            granted_nxt        = alloc_id[ID_W-1:0];
          end
        end else begin
          if (oob_r || !rd_data[free_bit]) begin
            status_nxt = STAT_NOT_ALLOC;
          end else begin
            wr.en             = 1'b1;
            wr.data[free_bit] = 1'b0;
          end
        end
      end
      default: begin
        busy = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= (state_r == ST_MOD);
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == ST_MOD) begin
      out_status_r     <= status_nxt;
      out_granted_id_r <= granted_nxt;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_status     = out_status_r;
  assign out_granted_id = out_granted_id_r;

  // The modify step never repeats: busy always falls again after it.
  assert property (@(posedge clk) disable iff (!rst_n) busy |=> !busy)
    else $error("modify step lasted more than one cycle");

  // A result follows every modify step and nothing else.
  assert property (@(posedge clk) disable iff (!rst_n) busy |=> out_valid)
    else $error("modify step produced no result");

  assert property (@(posedge clk) disable iff (!rst_n) out_valid |-> $past(busy))
    else $error("result without a modify step");

  // Failed requests and frees never carry an identifier.
  assert property (@(posedge clk) disable iff (!rst_n)
      (out_valid && (out_status != STAT_OK)) |-> (out_granted_id == '0))
    else $error("identifier reported with a failure status");

endmodule

>>> sim/bitmap_lowest_free_id_allocator_tb.sv
module bitmap_lowest_free_id_allocator_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import blfa_pkg::*;

  // One request word as the driver presents it, and the answer it should get.
  typedef struct packed {
    logic            kind;
    logic [ID_W-1:0] id;
  } id_req_t;

  typedef struct packed {
    status_t         status;
    logic [ID_W-1:0] gid;
  } id_result_t;

  // The random part stops after this many request words.
  localparam int RAND_ITEMS = 1828;
  // No new idle bursts are started in the final stretch of the random part.
  localparam int CALM_TAIL  = 150;

  logic            clk = 1'b0;
  logic            rst_n = 1'b0;
  logic            start = 1'b0;
  logic            busy;
  logic            in_req_type = REQ_ALLOC;
  logic [ID_W-1:0] in_id_to_free = '0;
  logic            out_valid;
  logic [1:0]      out_status;
  logic [ID_W-1:0] out_granted_id;

  // Requests waiting for the driver, and answers waiting for the block.
  id_req_t    req_q[$];
  id_result_t grant_q[$];

  // Our own copy of the allocation bitmap; a set bit means the id is held.
  logic [WORD_BITS-1:0] id_map [NUM_WORDS] = '{default: '0};

  bit word_taken = 1'b0;
  bit idle_on = 1'b0;
  int gap_left = 0;
  int fails = 0;

  bitmap_lowest_free_id_allocator DUT (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .busy           (busy),
    .in_req_type    (in_req_type),
    .in_id_to_free  (in_id_to_free),
    .out_valid      (out_valid),
    .out_status     (out_status),
    .out_granted_id (out_granted_id)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Applies one accepted request to the bitmap copy and returns the answer the
  // block owes for it. An allocate takes the lowest clear bit below the pool
  // size; a free clears a set bit or reports that the id was not held.
  function automatic id_result_t serve_request(id_req_t rq);
    id_result_t res;
    int         w;
    int         b;
    int         wi;
    int         bi;
    res.status = STAT_EMPTY;
    res.gid    = '0;
    if (rq.kind == REQ_ALLOC) begin
      for (w = 0; w < NUM_WORDS; w++) begin
        if (id_map[w] != '1) begin
          b = 0;
          while (id_map[w][b]) begin
            b++;
          end
          // A clear bit past the pool size means nothing usable is left.
          if (w * WORD_BITS + b < POOL_IDS) begin
            id_map[w][b] = 1'b1;
            res.status   = STAT_OK;
            res.gid      = ID_W'(w * WORD_BITS + b);
          end
          break;
        end
      end
    end else begin
      res.status = STAT_NOT_ALLOC;
      wi = int'(rq.id) / WORD_BITS;
      bi = int'(rq.id) % WORD_BITS;
      if (int'(rq.id) < POOL_IDS && wi < NUM_WORDS && id_map[wi][bi]) begin
        id_map[wi][bi] = 1'b0;
        res.status     = STAT_OK;
      end
    end
    return res;
  endfunction

  // Finds an id that is currently held, starting the search at a random point
  // so that frees land all over the pool. Falls back to a random id when the
  // pool is empty, which then turns into a free of something never granted.
  function automatic logic [ID_W-1:0] pick_held_id();
    int base;
    int k;
    int n;
    base = $urandom_range(0, POOL_IDS - 1);
    for (k = 0; k < POOL_IDS; k++) begin
      n = (base + k) % POOL_IDS;
      if (id_map[n / WORD_BITS][n % WORD_BITS]) begin
        return ID_W'(n);
      end
    end
    return ID_W'(base);
  endfunction

  function automatic void push_req(logic kind, logic [ID_W-1:0] id);
    id_req_t r;
    r.kind = kind;
    r.id   = id;
    req_q.push_back(r);
  endfunction

  // Monitor. Everything is sampled at the rising edge, so the values seen are
  // the ones the block itself saw. A result is checked against the oldest
  // outstanding answer; an accepted request runs through the bitmap copy.
  always @(posedge clk) begin
    id_result_t want;
    id_req_t    got;
    if (rst_n) begin
      if (out_valid) begin
        if (grant_q.size() == 0) begin
          fails++;
          $display("%0t: result word with nothing outstanding: status=%0d id=%0d",
                   $realtime, out_status, out_granted_id);
        end else begin
          want = grant_q.pop_front();
          if (out_status !== want.status) begin
            fails++;
            $display("%0t: out_status expected %0d, got %0d",
                     $realtime, want.status, out_status);
          end
          if (out_granted_id !== want.gid) begin
            fails++;
            $display("%0t: out_granted_id expected %0d, got %0d",
                     $realtime, want.gid, out_granted_id);
          end
        end
      end
      if (start && !busy) begin
        got.kind = in_req_type;
        got.id   = in_id_to_free;
        grant_q.push_back(serve_request(got));
        word_taken = 1'b1;
      end
    end
  end

  // Driver. Works on the falling edge: a word stays on the ports until the
  // monitor has seen it accepted, then the next one goes up, unless an idle
  // burst is pending. start gets exactly one assignment per falling edge.
  always @(negedge clk) begin
    id_req_t nxt;
    logic    hold;
    hold       = start && !word_taken;
    word_taken = 1'b0;
    if (rst_n && !hold) begin
      if (gap_left > 0) begin
        gap_left--;
      end else if (req_q.size() > 0) begin
        nxt = req_q.pop_front();
        in_req_type   <= nxt.kind;
        in_id_to_free <= nxt.id;
        hold = 1'b1;
        // The burst starts after this word, so it covers the busy cycle, the
        // result cycle or later, depending on its length.
        if (idle_on && $urandom_range(0, 7) == 0) begin
          gap_left = $urandom_range(1, 18);
        end
      end
    end
    start <= hold;
  end

  // Stimulus. A short directed part from the empty pool, then random phases
  // whose mix of allocates and frees swings the pool between nearly empty
  // and well filled.
  initial begin
    int done;
    int span;
    int k;
    int roll;
    int alloc_pct;

    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // From an empty pool: first grants, lowest-free after a hole, double
    // frees, and frees of ids that were never granted.
    idle_on = 1'b1;
    push_req(REQ_ALLOC, '1);
    push_req(REQ_ALLOC, '0);
    push_req(REQ_FREE, 12'd0);
    push_req(REQ_ALLOC, 12'h555);
    push_req(REQ_FREE, 12'd1);
    push_req(REQ_FREE, 12'd1);
    push_req(REQ_FREE, 12'd4095);
    push_req(REQ_FREE, 12'h555);
    push_req(REQ_FREE, 12'haaa);
    push_req(REQ_FREE, 12'd0);
    push_req(REQ_FREE, 12'd0);
    push_req(REQ_ALLOC, 12'haaa);

    // Frees of the top id and of ids on word edges, mixed with allocates
    // that must keep taking the lowest free id.
    push_req(REQ_FREE, 12'd4095);
    push_req(REQ_FREE, 12'd2047);
    push_req(REQ_FREE, 12'd64);
    push_req(REQ_ALLOC, '0);
    push_req(REQ_ALLOC, '0);
    push_req(REQ_ALLOC, '0);
    push_req(REQ_ALLOC, '0);
    push_req(REQ_FREE, 12'd63);
    push_req(REQ_FREE, 12'd63);
    push_req(REQ_ALLOC, '1);

    // Random phases. Frees mostly hit a held id so the pool really drains;
    // the rest are random ids or ids on word edges, which often turn into
    // double frees. Only a couple of words are queued ahead so that the held
    // ids are picked from an almost current bitmap.
    done = 0;
    while (done < RAND_ITEMS) begin
      span = $urandom_range(40, 200);
      case ($urandom_range(0, 4))
        0: alloc_pct = 5;
        1: alloc_pct = 30;
        2: alloc_pct = 50;
        3: alloc_pct = 70;
        default: alloc_pct = 95;
      endcase
      idle_on = ($urandom_range(0, 2) != 0);
      for (k = 0; k < span && done < RAND_ITEMS; k++) begin
        if (done >= RAND_ITEMS - CALM_TAIL) begin
          idle_on = 1'b0;
        end
        while (req_q.size() >= 2) begin
          @(posedge clk);
        end
        roll = $urandom_range(0, 99);
        if (roll < alloc_pct) begin
          push_req(REQ_ALLOC, ID_W'($urandom));
        end else begin
          roll = $urandom_range(0, 9);
          if (roll < 8) begin
            push_req(REQ_FREE, pick_held_id());
          end else if (roll == 8) begin
            push_req(REQ_FREE, ID_W'($urandom));
          end else begin
            push_req(REQ_FREE, ID_W'($urandom_range(0, NUM_WORDS - 1) * WORD_BITS +
                                     ($urandom_range(0, 1) ? WORD_BITS - 1 : 0)));
          end
        end
        done++;
      end
    end

    // Drain: every word handed over and every answer back, then a wait in which
    // no stray result may appear.
    while (req_q.size() != 0 || start || grant_q.size() != 0) begin
      @(posedge clk);
    end
    repeat (8) @(posedge clk);

    if (fails == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  // Watchdog, far beyond the slowest correct run.
  initial begin
    #2_000_000;
    $display("tb: failure");
    $finish;
  end

endmodule

>>> files.f
rtl/blfa_pkg.sv
rtl/blfa_store.sv
rtl/bitmap_lowest_free_id_allocator.sv
sim/bitmap_lowest_free_id_allocator_tb.sv
